/* src/aopd_pkg.sv */
package aopd_pkg;

    // register widths fixed by the port definition
    localparam int MODE_W       = 2;
    localparam int ON_TIME_W    = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;
    localparam int TIMER_BITS_DEF = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PORT_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_TIME_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_TIME_SECOND = 2'd2;

    // port modes
    localparam logic [MODE_W-1:0] MODE_PULSED_PAIR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PERM_PAIR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SINGLE_PERM = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SINGLE_BLINK = 2'd3;

    // item operations
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_ACTIVATE = 1'b1;

    // timer phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_PULSE     = 4'b0010,
        PH_BLINK_ON  = 4'b0100,
        PH_BLINK_OFF = 4'b1000
    } t_phase;

    // input beat
    typedef struct packed {
        logic operation;
        logic gate;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic pin_first;
        logic pin_second;
        logic busy_res;
    } t_out_beat;

endpackage

/* src/accessory_output_port_driver.sv */
// Output port driver of a model-railway accessory decoder.
// Input channel (i_in_valid / o_in_ready / i_in): one beat is either a tick of
// the time base or an activate command carrying a gate bit.
// Output channel (o_out_valid / i_out_ready / o_out): exactly one result beat
// per input beat, in order, giving both pin levels and the timer busy flag.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 port mode, 1 first on time, 2 second on time); writing the mode stops
// any running timer. Write only while no beat is in flight.
// An accepted beat passes the input register, then the result register; its
// result beat is valid once the result register takes it. Throughput: one beat
// per cycle while the receiver does not stall; the state update is a single
// decrement and compare between the two registers.
// Reset (synchronous, active low) clears the registers, the timer and the
// pins, and empties both stages.
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more beat; after that o_in_ready drops.
module accessory_output_port_driver #(
    parameter int TIMER_BITS = aopd_pkg::TIMER_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [aopd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [aopd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  aopd_pkg::t_in_beat                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output aopd_pkg::t_out_beat               o_out
);

    localparam int CMP_W = (TIMER_BITS > aopd_pkg::ON_TIME_W) ?
                           TIMER_BITS : aopd_pkg::ON_TIME_W;
    localparam logic [CMP_W-1:0] TMAX_W = CMP_W'({TIMER_BITS{1'b1}});
    localparam logic [TIMER_BITS-1:0] T_ONE = TIMER_BITS'(1);

    // configuration registers
    logic [aopd_pkg::MODE_W-1:0]    r_mode;
    logic [aopd_pkg::ON_TIME_W-1:0] r_on_first;
    logic [aopd_pkg::ON_TIME_W-1:0] r_on_second;

    // port state
    aopd_pkg::t_phase      r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_tick_count, n_tick_count;
    logic                  r_level_first, n_level_first;
    logic                  r_level_second, n_level_second;

    // pipeline stages
    logic                  r_in_valid;
    aopd_pkg::t_in_beat    r_in;
    logic                  r_out_valid;
    aopd_pkg::t_out_beat   r_out;

    logic out_free;
    logic step;
    logic mode_wr;

    logic [CMP_W-1:0]      first_w, second_w, sel_w;
    logic [TIMER_BITS-1:0] pulse_time;
    logic [TIMER_BITS-1:0] blink_time;
    logic                  expired;
    logic [TIMER_BITS-1:0] dec_count;

    // handshake
    assign out_free    = !r_out_valid || i_out_ready;
    assign step        = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign mode_wr     = i_cfg_we && (i_cfg_idx == aopd_pkg::REG_PORT_MODE);

    // on times saturated to the timer range
    assign first_w    = CMP_W'(r_on_first);
    assign second_w   = CMP_W'(r_on_second);
    assign sel_w      = r_in.gate ? second_w : first_w;
    assign pulse_time = TIMER_BITS'((sel_w > TMAX_W) ? TMAX_W : sel_w);
    always_comb begin
        blink_time = TIMER_BITS'((first_w > TMAX_W) ? TMAX_W : first_w);
        if (blink_time == '0) begin
            blink_time = T_ONE;
        end
    end

    // count down
    assign expired   = (r_tick_count <= T_ONE);
    assign dec_count = expired ? '0 : (r_tick_count - T_ONE);

    // state update for the beat in the input register
    always_comb begin
        n_phase        = r_phase;
        n_tick_count   = r_tick_count;
        n_level_first  = r_level_first;
        n_level_second = r_level_second;
        if (r_in.operation == aopd_pkg::OP_TICK) begin
            case (r_phase)
                aopd_pkg::PH_PULSE: begin
                    n_tick_count = dec_count;
                    if (expired) begin
                        n_level_first  = 1'b0;
                        n_level_second = 1'b0;
                        n_phase        = aopd_pkg::PH_IDLE;
                    end
                end
                aopd_pkg::PH_BLINK_ON: begin
                    n_tick_count = dec_count;
                    if (expired) begin
                        n_tick_count  = blink_time;
                        n_level_first = 1'b1;
                        n_phase       = aopd_pkg::PH_BLINK_OFF;
                    end
                end
                aopd_pkg::PH_BLINK_OFF: begin
                    n_tick_count = dec_count;
                    if (expired) begin
                        n_tick_count  = blink_time;
                        n_level_first = 1'b0;
                        n_phase       = aopd_pkg::PH_BLINK_ON;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            case (r_mode)
                aopd_pkg::MODE_PULSED_PAIR: begin
                    if (r_phase == aopd_pkg::PH_IDLE) begin
                        if (r_in.gate) begin
                            n_level_second = 1'b1;
                        end else begin
                            n_level_first = 1'b1;
                        end
                        if (pulse_time != '0) begin
                            n_tick_count = pulse_time;
                            n_phase      = aopd_pkg::PH_PULSE;
                        end
                    end
                end
                aopd_pkg::MODE_PERM_PAIR: begin
                    n_level_first  = !r_in.gate;
                    n_level_second = r_in.gate;
                end
                aopd_pkg::MODE_SINGLE_PERM: begin
                    n_level_first = !r_in.gate;
                end
                default: begin
                    if (!r_in.gate) begin
                        n_tick_count = T_ONE;
                        n_phase      = aopd_pkg::PH_BLINK_ON;
                    end else begin
                        n_level_first = 1'b0;
                        n_tick_count  = '0;
                        n_phase       = aopd_pkg::PH_IDLE;
                    end
                end
            endcase
        end
    end

    // configuration and port state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= aopd_pkg::MODE_PULSED_PAIR;
            r_on_first     <= '0;
            r_on_second    <= '0;
            r_phase        <= aopd_pkg::PH_IDLE;
            r_tick_count   <= '0;
            r_level_first  <= 1'b0;
            r_level_second <= 1'b0;
        end else begin
            // a mode write stops the timer
            if (mode_wr) begin
                r_mode       <= i_cfg_data[aopd_pkg::MODE_W-1:0];
                r_phase      <= aopd_pkg::PH_IDLE;
                r_tick_count <= '0;
            end else if (step) begin
                r_phase      <= n_phase;
                r_tick_count <= n_tick_count;
            end
            if (step) begin
                r_level_first  <= n_level_first;
                r_level_second <= n_level_second;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    aopd_pkg::REG_ON_TIME_FIRST: begin
                        r_on_first <= i_cfg_data;
                    end
                    aopd_pkg::REG_ON_TIME_SECOND: begin
                        r_on_second <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.pin_first  <= n_level_first;
            r_out.pin_second <= n_level_second;
            r_out.busy_res   <= (n_phase != aopd_pkg::PH_IDLE);
        end
    end

    // an idle port has an empty timer
    a_idle_timer_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == aopd_pkg::PH_IDLE) |-> (r_tick_count == '0))
        else $error("idle port with nonzero timer");

    // a running timer never sits at zero
    a_run_timer_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != aopd_pkg::PH_IDLE) |-> (r_tick_count != '0))
        else $error("running timer at zero");

    // single modes never touch the second pin
    a_single_second_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == aopd_pkg::MODE_SINGLE_PERM || r_mode == aopd_pkg::MODE_SINGLE_BLINK)
        |=> (r_level_second == $past(r_level_second)))
        else $error("second pin changed in a single mode");

    // a beat stalled in the input register keeps the port state
    a_stall_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!step && !i_cfg_we) |=> ($stable(r_phase) && $stable(r_tick_count)))
        else $error("port state moved without a beat");

endmodule
